>>> rtl/dsws_pkg.sv
// ----------------------------------------------------------------------------
// dsws_pkg
// Shared constants, codes and types of the depth sphere window scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package dsws_pkg;

	// frame geometry
	localparam int FRAME_WIDTH  = 640;
	localparam int FRAME_HEIGHT = 480;
	localparam int FRAME_CELLS  = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W       = $clog2(FRAME_CELLS);
	localparam int DIM_LIM      = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
	localparam int DIM_W        = $clog2(DIM_LIM + 1);

	// field widths
	localparam int COL_W  = 10;
	localparam int ROW_W  = 9;
	localparam int CRD_W  = 24;
	localparam int CFG_W  = 16;
	localparam int GRID_W = 7;
	localparam int CNT_W  = 13;
	localparam int GREY_W = 8;
	localparam int GRID_MAX = 64;

	// arithmetic unit widths
	localparam int DVD_W  = 44;   // divider dividend / quotient
	localparam int DVS_W  = 25;   // divider divisor
	localparam int RAD_W  = 32;   // root radicand
	localparam int ROOT_W = RAD_W / 2;
	localparam int MUL_W  = 25;
	localparam int PROD_W = 2 * MUL_W;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CFG_SPHERE_RADIUS = 2'd0,
		CFG_DEPTH_TOL     = 2'd1,
		CFG_PIXEL_SCALE   = 2'd2,
		CFG_SAMPLE_GRID   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [CRD_W-1:0] x;
		logic signed [CRD_W-1:0] y;
		logic signed [CRD_W-1:0] z;
		logic                    valid;
	} point_t;

endpackage

`default_nettype wire

>>> rtl/depth_sphere_window_scorer.sv
// ----------------------------------------------------------------------------
// depth_sphere_window_scorer
// Frame store of depth points plus a sequenced scorer that tests a clipped
// window of samples against a sphere behind the query center.
// ----------------------------------------------------------------------------
// Load item: written at the accept edge, busy stays low, next item next cycle.
// Query item: two 44-step divisions for setup, then per sample a read and the
//   validity and sphere tests, with the 16-step root unit for samples inside
//   the sphere, then a final 44-step division for the score if any sample counted.
// The result strobe done is high one cycle; the receiver cannot stall it.
// Reset: registers to defaults; frame contents undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_sphere_window_scorer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// command channel
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          opcode,
	input  wire logic [dsws_pkg::COL_W-1:0]    column,
	input  wire logic [dsws_pkg::ROW_W-1:0]    row,
	input  wire logic signed [dsws_pkg::CRD_W-1:0] coord_x,
	input  wire logic signed [dsws_pkg::CRD_W-1:0] coord_y,
	input  wire logic signed [dsws_pkg::CRD_W-1:0] coord_z,
	input  wire logic                          point_valid,
	// configuration write port
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [dsws_pkg::CFG_W-1:0]    cfg_data,
	// result
	output logic                               done,
	output logic [dsws_pkg::GREY_W-1:0]        grey_score,
	output logic [dsws_pkg::CNT_W-1:0]         window_samples,
	output logic [dsws_pkg::CNT_W-1:0]         region_hits
);
	import dsws_pkg::*;

	// Sequencer. Setup: pixel radius division, R^2, step division, window
	// clip. Per sample: read, dx^2, dy^2 and sphere test, root of D, the
	// near-radius test m*R >= ceil(sqrt(D))*zc, then the surface band test
	// done by squaring the band edges instead of a second root.
	typedef enum logic [4:0] {
		S_IDLE, S_PR_MUL, S_PR_DIV, S_RR, S_PR_WAIT, S_STEP_WAIT, S_WIN,
		S_ADDR, S_SAMPLE, S_DY, S_D, S_MR, S_ROOT, S_KZ, S_BCHK, S_HMUL,
		S_HIT, S_NEXT, S_SCORE, S_SCORE_WAIT, S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [CFG_W-1:0]  radius_q;
	logic [CFG_W-1:0]  tol_q;
	logic [CFG_W-1:0]  pscale_q;
	logic [GRID_W-1:0] grid_q;

	// query context
	logic [ROW_W-1:0]        row_q;
	logic [COL_W-1:0]        col_q;
	logic signed [CRD_W-1:0] cx_q;
	logic signed [CRD_W-1:0] cy_q;
	logic [CRD_W-1:0]        cz_q;
	logic [DVS_W-1:0]        zc_q;     // Z + R, positive
	logic [RAD_W-1:0]        rr_q;     // R^2
	logic [29:0]             span_q;
	logic signed [31:0]      vs_q;
	logic signed [31:0]      us_q;
	logic [DIM_W-1:0]        step_q;
	logic [DIM_W-1:0]        ulo_q;
	logic [DIM_W-1:0]        uhi_q;
	logic [DIM_W-1:0]        vhi_q;
	logic [DIM_W-1:0]        u_q;
	logic [DIM_W-1:0]        v_q;

	// per-sample
	logic [MUL_W-1:0]        ady_q;
	logic [CRD_W-1:0]        mz_q;
	logic signed [27:0]      l_q;      // lower band edge for the root
	logic signed [27:0]      h_q;      // upper band edge for the root
	logic [PROD_W-1:0]       dsq_q;
	logic [RAD_W-1:0]        d_q;
	logic [39:0]             mr_q;
	logic [ROOT_W:0]         k_q;
	logic                    lo_ok_q;

	logic [CNT_W-1:0]  samples_q;
	logic [CNT_W-1:0]  hits_q;
	logic [GREY_W-1:0] grey_q;

	// shared multiplier, result registered
	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [PROD_W-1:0] prod_q;

	// units
	logic             div_go;
	logic [DVD_W-1:0] div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic             div_done;
	logic [DVD_W-1:0] div_quo;
	logic              sq_go;
	logic              sq_done;
	logic [ROOT_W-1:0] sq_root;
	logic [ROOT_W:0]   sq_rem;

	// frame store
	point_t            wr_pt;
	point_t            rd_pt;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;

	logic              accept;
	logic [GRID_W-1:0] grid_c;
	logic [29:0]       span_c;
	logic [PROD_W-1:0] d_sum;
	logic signed [MUL_W-1:0] dx_c;
	logic signed [MUL_W-1:0] dy_c;
	logic [MUL_W-1:0]  adx_c;
	logic signed [26:0] diff_c;
	logic [RAD_W-1:0]  a_c;
	logic [DIM_W:0]    u_nx;
	logic [DIM_W:0]    v_nx;
	logic [DIM_W-1:0]  vlo_c;
	logic [DIM_W-1:0]  vhi_c;
	logic [DIM_W-1:0]  ulo_c;
	logic [DIM_W-1:0]  uhi_c;
	logic              hi_ok;
	logic [ROOT_W:0]   h1_c;
	logic [21:0]       grey_num;

	// trunc toward zero of (p*2^16 - pr) / 2^16
	function automatic logic signed [31:0] start_pix(input logic [DIM_W-1:0] p,
			input logic [DVD_W-1:0] pr);
		logic signed [DVD_W+1:0] t;
		logic [DVD_W+1:0]        n;
		t = $signed((DVD_W+2)'({p, 16'h0000})) - $signed({2'b00, pr});
		n = t[DVD_W+1] ? (DVD_W+2)'(-t) : (DVD_W+2)'(t);
		start_pix = t[DVD_W+1] ? -$signed(32'(n[DVD_W+1:16])) : $signed(32'(n[DVD_W+1:16]));
	endfunction

	function automatic logic [DIM_W-1:0] clip_dim(input logic signed [31:0] x,
			input int hi);
		logic signed [31:0] h;
		h = $signed(32'(hi));
		if (x < 0) begin
			clip_dim = '0;
		end else if (x > h) begin
			clip_dim = DIM_W'(hi);
		end else begin
			clip_dim = x[DIM_W-1:0];
		end
	endfunction

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign done   = (state_q == S_OUT);

	// a grid of 0 acts as 1, above the limit as the limit
	always_comb begin
		if (grid_q == '0) begin
			grid_c = GRID_W'(1);
		end else if (grid_q > GRID_W'(GRID_MAX)) begin
			grid_c = GRID_W'(GRID_MAX);
		end else begin
			grid_c = grid_q;
		end
	end

	// load path: write at the accept edge, out-of-frame loads dropped
	assign wr_pt.x     = coord_x;
	assign wr_pt.y     = coord_y;
	assign wr_pt.z     = coord_z;
	assign wr_pt.valid = point_valid;
	assign ram_we    = accept && (opcode == OP_LOAD) && (32'(column) < FRAME_WIDTH)
		&& (32'(row) < FRAME_HEIGHT);
	assign ram_waddr = ADDR_W'(row) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(column);
	assign ram_re    = (state_q == S_ADDR);
	assign ram_raddr = ADDR_W'(v_q) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(u_q);

	dsws_ram #(
		.DATA_W ($bits(point_t)),
		.DEPTH  (FRAME_CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_pt),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_pt)
	);

	dsws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	dsws_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (sq_go),
		.radicand (d_q),
		.done     (sq_done),
		.root     (sq_root),
		.rem      (sq_rem)
	);

	// datapath helpers
	always_comb begin
		span_c = div_quo[DVD_W-1:15] + 30'd1;
		dx_c   = MUL_W'(cx_q) - MUL_W'(rd_pt.x);
		dy_c   = MUL_W'(cy_q) - MUL_W'(rd_pt.y);
		adx_c  = dx_c[MUL_W-1] ? MUL_W'(-dx_c) : MUL_W'(dx_c);
		diff_c = $signed({2'b00, zc_q}) - 27'(rd_pt.z);
		d_sum  = dsq_q + prod_q;
		a_c    = rr_q - d_q;
		vlo_c  = clip_dim(vs_q, FRAME_HEIGHT);
		vhi_c  = clip_dim(vs_q + $signed({2'b00, span_q}), FRAME_HEIGHT);
		ulo_c  = clip_dim(us_q, FRAME_WIDTH);
		uhi_c  = clip_dim(us_q + $signed({2'b00, span_q}), FRAME_WIDTH);
		u_nx   = {1'b0, u_q} + {1'b0, step_q};
		v_nx   = {1'b0, v_q} + {1'b0, step_q};
		h1_c   = h_q[ROOT_W:0] + (ROOT_W+1)'(1);
		// s <= H  <=>  a < (H+1)^2 for 0 <= H < 2^16; larger H always holds
		if (h_q < 0) begin
			hi_ok = 1'b0;
		end else if (h_q >= 28'sd65536) begin
			hi_ok = 1'b1;
		end else begin
			hi_ok = 34'(a_c) < prod_q[33:0];
		end
		grey_num = {hits_q, 9'h000} - 22'({hits_q, 1'b0}) + 22'(samples_q);
	end

	// multiplier operands and unit starts
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		div_go  = 1'b0;
		div_dvd = '0;
		div_dvs = '0;
		sq_go   = 1'b0;
		unique case (state_q)
			S_PR_MUL: begin
				mul_a = MUL_W'(pscale_q);
				mul_b = MUL_W'(radius_q);
			end
			S_PR_DIV: begin
				// pixel_scale * R * 2560 over Z
				div_go  = 1'b1;
				div_dvd = DVD_W'({prod_q[31:0], 11'h000}) + DVD_W'({prod_q[31:0], 9'h000});
				div_dvs = DVS_W'(cz_q);
				mul_a   = MUL_W'(radius_q);
				mul_b   = MUL_W'(radius_q);
			end
			S_PR_WAIT: begin
				if (div_done) begin
					div_go  = 1'b1;
					div_dvd = DVD_W'(span_c) + DVD_W'(grid_c) - DVD_W'(1);
					div_dvs = DVS_W'(grid_c);
				end
			end
			S_SAMPLE: begin
				mul_a = adx_c;
				mul_b = adx_c;
			end
			S_DY: begin
				mul_a = ady_q;
				mul_b = ady_q;
			end
			S_D: begin
				mul_a = MUL_W'(mz_q);
				mul_b = MUL_W'(radius_q);
			end
			S_MR: begin
				sq_go = 1'b1;
			end
			S_KZ: begin
				mul_a = MUL_W'(k_q);
				mul_b = zc_q;
			end
			S_BCHK: begin
				mul_a = MUL_W'(l_q[ROOT_W:0]);
				mul_b = MUL_W'(l_q[ROOT_W:0]);
			end
			S_HMUL: begin
				mul_a = MUL_W'(h1_c);
				mul_b = MUL_W'(h1_c);
			end
			S_SCORE: begin
				if (samples_q != '0) begin
					div_go  = 1'b1;
					div_dvd = DVD_W'(grey_num);
					div_dvs = DVS_W'({samples_q, 1'b0});
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= CFG_W'(6554);
			tol_q    <= CFG_W'(1311);
			pscale_q <= CFG_W'(17741);
			grid_q   <= GRID_W'(25);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SPHERE_RADIUS: radius_q <= cfg_data;
				CFG_DEPTH_TOL:     tol_q    <= cfg_data;
				CFG_PIXEL_SCALE:   pscale_q <= cfg_data;
				CFG_SAMPLE_GRID:   grid_q   <= cfg_data[GRID_W-1:0];
			endcase
		end
	end

	// sequencer with its registered outputs and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			samples_q <= '0;
			hits_q    <= '0;
			grey_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && (opcode == OP_QUERY)) begin
						row_q     <= row;
						col_q     <= column;
						cx_q      <= coord_x;
						cy_q      <= coord_y;
						cz_q      <= coord_z;
						zc_q      <= DVS_W'(coord_z) + DVS_W'(radius_q);
						samples_q <= '0;
						hits_q    <= '0;
						// invalid or non-positive center scores zero
						if (point_valid && (coord_z > 0)) begin
							state_q <= S_PR_MUL;
						end else begin
							state_q <= S_SCORE;
						end
					end
				end
				S_PR_MUL: state_q <= S_PR_DIV;
				S_PR_DIV: state_q <= S_RR;
				S_RR: begin
					rr_q    <= prod_q[RAD_W-1:0];
					state_q <= S_PR_WAIT;
				end
				S_PR_WAIT: begin
					if (div_done) begin
						span_q  <= span_c;
						vs_q    <= start_pix(DIM_W'(row_q), div_quo);
						us_q    <= start_pix(DIM_W'(col_q), div_quo);
						state_q <= S_STEP_WAIT;
					end
				end
				S_STEP_WAIT: begin
					if (div_done) begin
						// a step past the frame yields one sample per axis
						if (div_quo > DVD_W'(DIM_LIM)) begin
							step_q <= DIM_W'(DIM_LIM);
						end else begin
							step_q <= div_quo[DIM_W-1:0];
						end
						state_q <= S_WIN;
					end
				end
				S_WIN: begin
					ulo_q <= ulo_c;
					uhi_q <= uhi_c;
					vhi_q <= vhi_c;
					u_q   <= ulo_c;
					v_q   <= vlo_c;
					if ((vlo_c >= vhi_c) || (ulo_c >= uhi_c)) begin
						state_q <= S_SCORE;
					end else begin
						state_q <= S_ADDR;
					end
				end
				S_ADDR: state_q <= S_SAMPLE;
				S_SAMPLE: begin
					ady_q   <= dy_c[MUL_W-1] ? MUL_W'(-dy_c) : MUL_W'(dy_c);
					mz_q    <= rd_pt.z[CRD_W-1] ? CRD_W'(-rd_pt.z) : CRD_W'(rd_pt.z);
					l_q     <= 28'(diff_c) - 28'(tol_q);
					h_q     <= 28'(diff_c) + 28'(tol_q);
					// unmeasured point counts but never hits
					if (!rd_pt.valid) begin
						samples_q <= samples_q + 1'b1;
						state_q   <= S_NEXT;
					end else begin
						state_q <= S_DY;
					end
				end
				S_DY: begin
					dsq_q   <= prod_q;
					state_q <= S_D;
				end
				S_D: begin
					d_q <= d_sum[RAD_W-1:0];
					// outside the sphere: not counted
					if (d_sum > PROD_W'(rr_q)) begin
						state_q <= S_NEXT;
					end else begin
						state_q <= S_MR;
					end
				end
				S_MR: begin
					mr_q    <= prod_q[39:0];
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (sq_done) begin
						k_q     <= (ROOT_W+1)'(sq_root) + (ROOT_W+1)'(sq_rem != '0);
						state_q <= S_KZ;
					end
				end
				S_KZ: state_q <= S_BCHK;
				S_BCHK: begin
					// floor(m*R/zc)^2 >= D  <=>  m*R >= ceil(sqrt(D))*zc
					if (42'(mr_q) < prod_q[41:0]) begin
						state_q <= S_NEXT;
					end else begin
						samples_q <= samples_q + 1'b1;
						state_q   <= S_HMUL;
					end
				end
				S_HMUL: begin
					// s >= L  <=>  a >= L^2 for 0 < L < 2^17
					if (l_q <= 0) begin
						lo_ok_q <= 1'b1;
					end else if (l_q < 28'sd131072) begin
						lo_ok_q <= 34'(a_c) >= prod_q[33:0];
					end else begin
						lo_ok_q <= 1'b0;
					end
					state_q <= S_HIT;
				end
				S_HIT: begin
					if (lo_ok_q && hi_ok) begin
						hits_q <= hits_q + 1'b1;
					end
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (u_nx < {1'b0, uhi_q}) begin
						u_q     <= u_nx[DIM_W-1:0];
						state_q <= S_ADDR;
					end else if (v_nx < {1'b0, vhi_q}) begin
						u_q     <= ulo_q;
						v_q     <= v_nx[DIM_W-1:0];
						state_q <= S_ADDR;
					end else begin
						state_q <= S_SCORE;
					end
				end
				S_SCORE: begin
					if (samples_q == '0) begin
						grey_q  <= '0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_SCORE_WAIT;
					end
				end
				S_SCORE_WAIT: begin
					if (div_done) begin
						grey_q  <= div_quo[GREY_W-1:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign grey_score     = grey_q;
	assign window_samples = samples_q;
	assign region_hits    = hits_q;

endmodule

`default_nettype wire

>>> rtl/dsws_ram.sv
// ----------------------------------------------------------------------------
// dsws_ram
// Simple dual-port frame memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dsws_ram #(
	parameter int DATA_W = 73,
	parameter int DEPTH  = 307200
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DATA_W-1:0]        wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/dsws_div.sv
// ----------------------------------------------------------------------------
// dsws_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dsws_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        go,
	input  wire logic [dsws_pkg::DVD_W-1:0]  dividend,
	input  wire logic [dsws_pkg::DVS_W-1:0]  divisor,
	output logic                             done,
	output logic [dsws_pkg::DVD_W-1:0]       quotient
);
	import dsws_pkg::*;

	localparam int CNT_BITS = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]    quo_q;
	logic [DVS_W-1:0]    rem_q;
	logic [DVS_W-1:0]    dvs_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                run_q;
	logic                done_q;

	logic [DVS_W:0]      sh;
	logic                ge;
	logic [DVS_W:0]      diff;

	always_comb begin
		sh   = {rem_q, quo_q[DVD_W-1]};
		ge   = sh >= {1'b0, dvs_q};
		diff = sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CNT_BITS'(DVD_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> rtl/dsws_sqrt.sv
// ----------------------------------------------------------------------------
// dsws_sqrt
// Digit-by-digit integer square root, one root bit per cycle, with remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module dsws_sqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         go,
	input  wire logic [dsws_pkg::RAD_W-1:0]   radicand,
	output logic                              done,
	output logic [dsws_pkg::ROOT_W-1:0]       root,
	output logic [dsws_pkg::ROOT_W:0]         rem
);
	import dsws_pkg::*;

	localparam int CNT_BITS = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]    rad_q;
	logic [ROOT_W-1:0]   root_q;
	logic [ROOT_W:0]     rem_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                run_q;
	logic                done_q;

	logic [ROOT_W+2:0]   rem_sh;
	logic [ROOT_W+2:0]   trial;
	logic                ge;
	logic [ROOT_W+2:0]   diff;

	always_comb begin
		rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		ge     = rem_sh >= trial;
		diff   = rem_sh - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CNT_BITS'(ROOT_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			root_q <= {root_q[ROOT_W-2:0], ge};
			rem_q  <= ge ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
		end
	end

	assign done = done_q;
	assign root = root_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

>>> rtl/dsws_checker.sv
// ----------------------------------------------------------------------------
// dsws_checker
// Port-level checks of the scorer's command and result timing and result values.
// ----------------------------------------------------------------------------
`default_nettype none

module dsws_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          opcode,
	input wire logic                          done,
	input wire logic [dsws_pkg::GREY_W-1:0]   grey_score,
	input wire logic [dsws_pkg::CNT_W-1:0]    window_samples,
	input wire logic [dsws_pkg::CNT_W-1:0]    region_hits
);
	import dsws_pkg::*;

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (opcode == OP_QUERY)) |=> busy)
		else $error("query item did not raise busy");

	a_done_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a query");

	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("query ended without a result");

	a_hits_le_samples: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (region_hits <= window_samples))
		else $error("more hits than samples");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (window_samples == '0)) |-> (grey_score == '0))
		else $error("nonzero score on an empty window");

endmodule

bind depth_sphere_window_scorer dsws_checker u_dsws_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.opcode         (opcode),
	.done           (done),
	.grey_score     (grey_score),
	.window_samples (window_samples),
	.region_hits    (region_hits)
);

`default_nettype wire

>>> bench/score_checker.sv
// ----------------------------------------------------------------------------
// score_checker
// Watches the item, configuration and result ports of the depth sphere
// window scorer. Keeps its own copy of the frame and registers, predicts
// the score of each query item and compares it with the strobed result.
// ----------------------------------------------------------------------------
`default_nettype none

module score_checker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic                                 busy,
	input  wire logic                                 opcode,
	input  wire logic [dsws_pkg::COL_W-1:0]           column,
	input  wire logic [dsws_pkg::ROW_W-1:0]           row,
	input  wire logic signed [dsws_pkg::CRD_W-1:0]    coord_x,
	input  wire logic signed [dsws_pkg::CRD_W-1:0]    coord_y,
	input  wire logic signed [dsws_pkg::CRD_W-1:0]    coord_z,
	input  wire logic                                 point_valid,
	input  wire logic                                 cfg_we,
	input  wire logic [1:0]                           cfg_index,
	input  wire logic [dsws_pkg::CFG_W-1:0]           cfg_data,
	input  wire logic                                 done,
	input  wire logic [dsws_pkg::GREY_W-1:0]          grey_score,
	input  wire logic [dsws_pkg::CNT_W-1:0]           window_samples,
	input  wire logic [dsws_pkg::CNT_W-1:0]           region_hits,
	output int                                        errors,
	output int                                        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import dsws_pkg::*;

	typedef struct packed {
		logic [GREY_W-1:0] grey;
		logic [CNT_W-1:0]  samples;
		logic [CNT_W-1:0]  hits;
	} score_t;

	logic [CFG_W-1:0]  radius_q, tol_q, scale_q;
	logic [GRID_W-1:0] grid_q;
	point_t            frame_pts [int];
	score_t            score_q [$];

	function automatic longint clip(longint x, longint hi);
		if (x > hi) x = hi;
		if (x < 0) x = 0;
		return x;
	endfunction

	// floor square root, bit by bit from the top
	function automatic longint floor_root(longint a);
		longint r;
		r = 0;
		for (int b = 16; b >= 0; b--)
			if ((r | (64'sd1 << b)) * (r | (64'sd1 << b)) <= a) r = r | (64'sd1 << b);
		return r;
	endfunction

	function automatic score_t score_window(longint col, longint rw, longint cx, longint cy,
	                                        longint cz, bit ok);
		longint r, t, zc, grid, pr, span, stp, vlo, vhi, ulo, uhi;
		longint dx, dy, d, a, mz, nr, b, bz, cnt, hit;
		point_t p;
		score_t s;
		s = '0;
		cnt = 0;
		hit = 0;
		if (ok && cz > 0) begin
			r = radius_q;
			t = tol_q;
			zc = cz + r;
			grid = grid_q;
			if (grid < 1) grid = 1;
			if (grid > GRID_MAX) grid = GRID_MAX;
			pr = (longint'(scale_q) * r * 2560) / cz;
			span = (pr >>> 15) + 1;
			stp = (span + grid - 1) / grid;
			vlo = clip((rw * 65536 - pr) / 65536, FRAME_HEIGHT);
			vhi = clip((rw * 65536 - pr) / 65536 + span, FRAME_HEIGHT);
			ulo = clip((col * 65536 - pr) / 65536, FRAME_WIDTH);
			uhi = clip((col * 65536 - pr) / 65536 + span, FRAME_WIDTH);
			for (longint v = vlo; v < vhi; v += stp) begin
				for (longint u = ulo; u < uhi; u += stp) begin
					p = frame_pts[int'(v * FRAME_WIDTH + u)];
					if (!p.valid) begin
						cnt++;
						continue;
					end
					dx = cx - longint'(p.x);
					dy = cy - longint'(p.y);
					d = dx * dx + dy * dy;
					a = r * r - d;
					mz = (p.z < 0) ? -longint'(p.z) : longint'(p.z);
					nr = (mz * r) / zc;
					if (nr > (64'sd1 << 25)) nr = 64'sd1 << 25;
					b = nr * nr - d;
					if (a < 0 || b < 0) continue;
					cnt++;
					bz = zc - floor_root(a);
					if (bz >= longint'(p.z) - t && bz <= longint'(p.z) + t) hit++;
				end
			end
		end
		if (cnt != 0) s.grey = (hit * 510 + cnt) / (2 * cnt);
		s.samples = cnt;
		s.hits = hit;
		return s;
	endfunction

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		score_t want;
		if (!arst_n) begin
			radius_q <= 16'd6554;
			tol_q <= 16'd1311;
			scale_q <= 16'd17741;
			grid_q <= 7'd25;
			outstanding <= 0;
		end else begin
			// result first: a query accepted at this edge cannot finish at it
			if (done) begin
				if (score_q.size() == 0) begin
					errors++;
					$display("%0t: result with none expected: grey %0d samples %0d hits %0d",
					         $time, grey_score, window_samples, region_hits);
				end else begin
					want = score_q.pop_front();
					if (want.grey !== grey_score || want.samples !== window_samples ||
					    want.hits !== region_hits) begin
						errors++;
						$display("%0t: score mismatch: expected grey %0d samples %0d hits %0d,",
						         $time, want.grey, want.samples, want.hits,
						         " actual grey %0d samples %0d hits %0d",
						         grey_score, window_samples, region_hits);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SPHERE_RADIUS: radius_q <= cfg_data;
					CFG_DEPTH_TOL:     tol_q <= cfg_data;
					CFG_PIXEL_SCALE:   scale_q <= cfg_data;
					CFG_SAMPLE_GRID:   grid_q <= cfg_data[GRID_W-1:0];
				endcase
			end
			if (start && !busy) begin
				if (op_t'(opcode) == OP_LOAD) begin
					if (column < FRAME_WIDTH && row < FRAME_HEIGHT)
						frame_pts[int'(row) * FRAME_WIDTH + int'(column)] =
							'{coord_x, coord_y, coord_z, point_valid};
				end else begin
					score_q.push_back(score_window(column, row, coord_x, coord_y, coord_z,
					                               point_valid));
				end
			end
			outstanding <= score_q.size();
		end
	end

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives load and query items and register writes into the depth sphere
// window scorer; the checker beside it predicts and compares every score.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import dsws_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;

	logic                     clk, arst_n;
	logic                     start, busy, opcode, point_valid;
	logic [COL_W-1:0]         column;
	logic [ROW_W-1:0]         row;
	logic signed [CRD_W-1:0]  coord_x, coord_y, coord_z;
	logic                     cfg_we;
	logic [1:0]               cfg_index;
	logic [CFG_W-1:0]         cfg_data;
	logic                     done;
	logic [GREY_W-1:0]        grey_score;
	logic [CNT_W-1:0]         window_samples, region_hits;
	int                       errors, outstanding;

	// shadow of the registers, used only to shape the stimulus
	longint sh_radius, sh_tol, sh_scale, sh_grid;
	bit     loaded [FRAME_CELLS];   // frame cells written since reset
	bit     quiet;                  // no idle gaps while set
	int     stall_cycles;

	depth_sphere_window_scorer dut (.*);

	score_checker chk (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// watchdog: cycles without an accepted item or a result
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic longint sat24(longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	// Random idle gap before an item, about 31 in 100.
	task automatic maybe_idle();
		if (!quiet && $urandom_range(0, 99) < 31) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Present one item and hold it until the accept edge; returns in that step.
	task automatic send_item(op_t op, int col, int rw, longint x, longint y, longint z,
	                         bit ok);
		maybe_idle();
		start <= 1'b1;
		opcode <= op;
		column <= col;
		row <= rw;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		point_valid <= ok;
		if (op == OP_LOAD && col < FRAME_WIDTH && rw < FRAME_HEIGHT)
			loaded[rw * FRAME_WIDTH + col] = 1'b1;
		do @(posedge clk); while (busy);
	endtask

	// Let the block finish: no result pending, not busy, then a trailing idle
	// wait, since a load leaves nothing to wait for.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SPHERE_RADIUS: sh_radius = value;
			CFG_DEPTH_TOL:     sh_tol = value;
			CFG_PIXEL_SCALE:   sh_scale = value;
			CFG_SAMPLE_GRID:   sh_grid = value & 7'h7f;
		endcase
	endtask

	task automatic set_regs(int rad, int tol, int scl, int grid);
		write_reg(CFG_SPHERE_RADIUS, rad);
		write_reg(CFG_DEPTH_TOL, tol);
		write_reg(CFG_PIXEL_SCALE, scl);
		write_reg(CFG_SAMPLE_GRID, grid);
	endtask

	// Loads every window cell the query will read and has not been written,
	// mostly with points near the sphere surface so that hits happen.
	task automatic fill_window(longint col, longint rw, longint cx, longint cy, longint cz);
		longint grid, pr, span, stp, vs, us, vlo, vhi, ulo, uhi;
		longint dx, dy, d, pz;
		int     mode;
		grid = (sh_grid < 1) ? 1 : (sh_grid > GRID_MAX) ? GRID_MAX : sh_grid;
		pr = (sh_scale * sh_radius * 2560) / cz;
		span = (pr >>> 15) + 1;
		stp = (span + grid - 1) / grid;
		vs = (rw * 65536 - pr) / 65536;
		us = (col * 65536 - pr) / 65536;
		vlo = (vs < 0) ? 0 : (vs > FRAME_HEIGHT) ? FRAME_HEIGHT : vs;
		vhi = (vs + span < 0) ? 0 : (vs + span > FRAME_HEIGHT) ? FRAME_HEIGHT : vs + span;
		ulo = (us < 0) ? 0 : (us > FRAME_WIDTH) ? FRAME_WIDTH : us;
		uhi = (us + span < 0) ? 0 : (us + span > FRAME_WIDTH) ? FRAME_WIDTH : us + span;
		for (longint v = vlo; v < vhi; v += stp) begin
			for (longint u = ulo; u < uhi; u += stp) begin
				if (loaded[v * FRAME_WIDTH + u]) continue;
				mode = $urandom_range(0, 99);
				if (mode < 15) begin
					// invalid point: counted, never a hit
					send_item(OP_LOAD, u, v, $urandom, $urandom, $urandom, 1'b0);
				end else if (mode < 35) begin
					send_item(OP_LOAD, u, v, sat24(cx + $urandom_range(0, 200000) - 100000),
					          sat24(cy + $urandom_range(0, 200000) - 100000),
					          $urandom, 1'b1);
				end else begin
					dx = longint'($urandom_range(0, 2 * sh_radius)) - sh_radius;
					dy = longint'($urandom_range(0, 2 * sh_radius)) - sh_radius;
					d = dx * dx + dy * dy;
					if (d > sh_radius * sh_radius) begin
						dx = sh_radius / 2;
						dy = 0;
						d = dx * dx;
					end
					pz = cz + sh_radius - longint'($floor($sqrt(real'(sh_radius * sh_radius - d))))
					     + longint'($urandom_range(0, 2 * sh_tol + 2)) - sh_tol - 1;
					send_item(OP_LOAD, u, v, sat24(cx + dx), sat24(cy + dy), sat24(pz), 1'b1);
				end
			end
		end
	endtask

	task automatic query(int col, int rw, longint cx, longint cy, longint cz, bit ok);
		if (ok && cz > 0) fill_window(col, rw, cx, cy, cz);
		send_item(OP_QUERY, col, rw, cx, cy, cz, ok);
	endtask

	initial begin
		int     pick, col, rw;
		longint cx, cy, cz;
		start = 1'b0;
		opcode = 1'b0;
		column = '0;
		row = '0;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		point_valid = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		stall_cycles = 0;
		quiet = 1'b0;
		sh_radius = 6554;
		sh_tol = 1311;
		sh_scale = 17741;
		sh_grid = 25;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed part at reset values
		send_item(OP_LOAD, 639, 479, -8388608, 8388607, 8388607, 1'b1);
		send_item(OP_LOAD, 0, 0, 8388607, -8388608, -8388608, 1'b1);
		// loads outside the frame are dropped
		send_item(OP_LOAD, 640, 0, 1, 2, 3, 1'b1);
		send_item(OP_LOAD, 1023, 511, -1, -1, -1, 1'b1);
		send_item(OP_LOAD, 5, 480, 7, 7, 7, 1'b0);
		// invalid centers: not measured, zero and negative depth
		send_item(OP_QUERY, 100, 100, 0, 0, 65536, 1'b0);
		send_item(OP_QUERY, 100, 100, 0, 0, 0, 1'b1);
		send_item(OP_QUERY, 100, 100, 0, 0, -8388608, 1'b1);
		send_item(OP_QUERY, 100, 100, 0, 0, -1, 1'b1);
		// farthest center, corners clipped
		query(0, 0, 0, 0, 8388607, 1'b1);
		query(639, 479, -8388608, 8388607, 8388607, 1'b1);
		// center outside the frame: window clipped or empty
		query(1023, 511, 0, 0, 4194304, 1'b1);
		query(645, 482, 1000, -1000, 1048576, 1'b1);
		// windows at the default grid, 8 m away, and one at the least positive depth
		query(320, 240, 12345, -54321, 524288, 1'b1);
		query(320, 240, -8388608, -8388608, 524288, 1'b1);
		query(321, 241, 8388607, 8388607, 1, 1'b1);
		drain();

		// random phases, each with its own register setting
		for (int ph = 0; ph < 9; ph++) begin
			quiet = (ph == 3);
			case (ph)
				0: set_regs(1, 0, 1, 0);                        // grid 0 acts as 1
				1: set_regs(65535, 65535, 65535, $urandom_range(1, 4));
				default: set_regs(($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(1, 65535),
				                  $urandom_range(0, 65535),
				                  ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, 65535),
				                  $urandom_range(1, 6));
			endcase
			for (int n = 0; n < 80; n++) begin
				pick = $urandom_range(0, 99);
				col = ($urandom_range(0, 9) == 0) ? $urandom_range(640, 1023)
				                                  : $urandom_range(0, 639);
				rw = ($urandom_range(0, 9) == 0) ? $urandom_range(480, 511)
				                                 : $urandom_range(0, 479);
				cx = longint'($urandom_range(0, 8388607)) - 4194304;
				cy = longint'($urandom_range(0, 8388607)) - 4194304;
				cz = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8388607)
				                                 : $urandom_range(16384, 1048576);
				if (pick < 25)
					send_item(OP_LOAD, col, rw, sat24(longint'($urandom) >>> 8),
					          sat24(longint'($urandom) >>> 8), sat24(longint'($urandom) >>> 8),
					          $urandom_range(0, 1));
				else if (pick < 32)
					send_item(OP_QUERY, col, rw, cx, cy,
					          ($urandom_range(0, 1) == 1) ? -longint'($urandom_range(0, 8388608))
					                                      : cz, 1'b0);
				else
					query(col, rw, cx, cy, cz, 1'b1);
			end
			drain();
		end

		// largest grids: 64 and an out-of-range value that acts as 64
		quiet = 1'b0;
		set_regs(6554, 1311, 17741, GRID_MAX);
		query(200, 150, 3000, -3000, 262144, 1'b1);
		query(200, 150, -3000, 3000, 1, 1'b1);
		drain();
		write_reg(CFG_SAMPLE_GRID, 127);
		query(210, 160, 500, 500, 262144, 1'b1);
		drain();
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
